// ===== src/ebas_pkg.sv =====
package ebas_pkg;

	// Field and register widths
	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int ELAPSED_W       = 10;
	localparam int ALPHA_W         = 8;
	localparam int PHASE_W         = 2;
	localparam int LFSR_W          = 16;

	// Sigmoid curve
	localparam int CURVE_ENTRIES = 64;
	localparam int CURVE_IDX_W   = $clog2(CURVE_ENTRIES);

	localparam logic [ALPHA_W-1:0] ALPHA_OPEN   = 8'h00;
	localparam logic [ALPHA_W-1:0] ALPHA_CLOSED = 8'hFF;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TICKS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSED_TICKS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_MIN_TICKS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_SPAN_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED      = 3'd5;

	// Register reset values
	localparam logic [CFG_W-1:0] RESET_CLOSE  = 16'd80;
	localparam logic [CFG_W-1:0] RESET_CLOSED = 16'd60;
	localparam logic [CFG_W-1:0] RESET_OPEN   = 16'd120;
	localparam logic [CFG_W-1:0] RESET_MIN    = 16'd2000;
	localparam logic [CFG_W-1:0] RESET_SPAN   = 16'd5000;
	localparam logic [CFG_W-1:0] RESET_SEED   = 16'd44257;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE,
		PH_CLOSING,
		PH_CLOSED,
		PH_OPENING
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] close_ticks;
		logic [CFG_W-1:0] closed_ticks;
		logic [CFG_W-1:0] open_ticks;
		logic [CFG_W-1:0] delay_min_ticks;
		logic [CFG_W-1:0] delay_span_ticks;
	} cfg_regs_t;

	// controller -> datapath
	typedef struct packed {
		logic load_sum;
		logic eval;
		logic div_step;
		logic write_curve;
		logic draw_mul;
		logic draw_add;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic reach;
		logic curve;
		logic wrap;
	} dp_stat_t;

	// Galois step, right shift; an all-zero register restarts at one
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] v;
		v = (s == '0) ? LFSR_W'(1) : s;
		return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
	endfunction

	// Idle delay drawn from the reset seed and reset registers
	function automatic logic [31:0] reset_delay(input int tw);
		logic [LFSR_W-1:0] l;
		longint d;
		longint m;
		l = lfsr_next(RESET_SEED);
		d = longint'(RESET_MIN) + ((longint'(RESET_SPAN) * longint'(l)) >>> 16);
		m = (longint'(1) <<< tw) - longint'(1);
		if (d > m) begin
			d = m;
		end
		return 32'(d);
	endfunction

	// round(255 / (1 + exp(-12 * (i / 64 - 0.5))))
	localparam logic [ALPHA_W-1:0] CURVE_ROM [CURVE_ENTRIES] = '{
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
		8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd10,
		8'd12,  8'd14,  8'd17,  8'd20,  8'd24,  8'd29,  8'd34,  8'd40,
		8'd47,  8'd54,  8'd62,  8'd72,  8'd82,  8'd93,  8'd104, 8'd116,
		8'd128, 8'd139, 8'd151, 8'd162, 8'd173, 8'd183, 8'd193, 8'd201,
		8'd208, 8'd215, 8'd221, 8'd226, 8'd231, 8'd235, 8'd238, 8'd241,
		8'd243, 8'd245, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252,
		8'd252, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254
	};

endpackage

// ===== src/ebas_ctrl.sv =====
module ebas_ctrl import ebas_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_free,
	output logic     out_load,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam int CNT_W = $clog2(CURVE_IDX_W + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_CURVE,
		S_DRAW_MUL,
		S_DRAW_ADD,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (stat.curve && !stat.reach) begin
						state_q <= S_DIV;
						cnt_q   <= CNT_W'(CURVE_IDX_W);
					end else if (stat.wrap) begin
						state_q <= S_DRAW_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_CURVE;
					end
				end
				S_CURVE:    state_q <= S_DONE;
				S_DRAW_MUL: state_q <= S_DRAW_ADD;
				S_DRAW_ADD: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.load_sum    = (state_q == S_IDLE) && in_valid;
		cmd.eval        = (state_q == S_EVAL);
		cmd.div_step    = (state_q == S_DIV);
		cmd.write_curve = (state_q == S_CURVE);
		cmd.draw_mul    = (state_q == S_DRAW_MUL);
		cmd.draw_add    = (state_q == S_DRAW_ADD);
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && out_free;

endmodule

// ===== src/ebas_dpath.sv =====
module ebas_dpath import ebas_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  cfg_regs_t             cfg,
	input  logic                  seed_load,
	input  logic [CFG_W-1:0]      seed_data,
	input  logic [ELAPSED_W-1:0]  elapsed,
	output dp_stat_t              stat,
	output logic [ALPHA_W-1:0]    cur_alpha,
	output phase_t                cur_phase
);

	localparam int TW  = TIMER_WIDTH;
	localparam int SW  = ((TW > ELAPSED_W) ? TW : ELAPSED_W) + 1;  // tick sum
	localparam int CW  = (TW > CFG_W) ? TW : CFG_W;                // compare
	localparam int DSW = (TW > CFG_W + 1) ? TW : CFG_W + 1;        // delay sum
	localparam int QW  = CURVE_IDX_W;
	localparam int DW  = CFG_W + QW;                               // dividend
	localparam int PW  = 2 * CFG_W;

	localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};
	localparam logic [TW-1:0] RESET_IDLE_DELAY = TW'(reset_delay(TW));
	localparam logic [QW-1:0] CURVE_LAST = QW'(CURVE_ENTRIES - 1);

	phase_t              phase_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [TW-1:0]       time_q;
	logic [TW-1:0]       idle_delay_q;
	logic [LFSR_W-1:0]   lfsr_q;

	logic [TW-1:0]       t_q;
	logic [CFG_W:0]      rem_q;
	logic [QW-1:0]       low_q;
	logic [QW-1:0]       quot_q;
	logic [PW-1:0]       prod_q;

	logic [SW-1:0]       sum;
	logic [CW-1:0]       t_x;
	logic [CW-1:0]       dur_x;
	logic                reach;
	logic [CFG_W-1:0]    curve_dur;
	logic [DW-1:0]       dvd;
	logic [CFG_W:0]      trial;
	logic                qbit;
	logic [QW-1:0]       rom_idx;
	logic [ALPHA_W-1:0]  rom_val;
	logic [LFSR_W-1:0]   lfsr_adv;
	logic [DSW-1:0]      dsum;

	// saturating tick accumulation
	assign sum = SW'(time_q) + SW'(elapsed);

	always_comb begin
		case (phase_q)
			PH_IDLE:    dur_x = CW'(idle_delay_q);
			PH_CLOSING: dur_x = CW'(cfg.close_ticks);
			PH_CLOSED:  dur_x = CW'(cfg.closed_ticks);
			PH_OPENING: dur_x = CW'(cfg.open_ticks);
			default:    dur_x = CW'(cfg.open_ticks);
		endcase
	end

	assign t_x   = CW'(t_q);
	assign reach = (t_x >= dur_x);

	assign stat.reach = reach;
	assign stat.curve = (phase_q == PH_CLOSING) || (phase_q == PH_OPENING);
	assign stat.wrap  = (phase_q == PH_OPENING) && reach;

	// restoring divider: index = t * CURVE_ENTRIES / dur, t < dur
	assign curve_dur = (phase_q == PH_CLOSING) ? cfg.close_ticks : cfg.open_ticks;
	assign dvd       = DW'(t_x[CFG_W-1:0]) * DW'(CURVE_ENTRIES);
	assign trial     = {rem_q[CFG_W-1:0], low_q[QW-1]};
	assign qbit      = (trial >= {1'b0, curve_dur});

	assign rom_idx = (quot_q > CURVE_LAST) ? CURVE_LAST : quot_q;
	assign rom_val = CURVE_ROM[rom_idx];

	assign lfsr_adv = lfsr_next(lfsr_q);
	assign dsum     = DSW'(cfg.delay_min_ticks) + DSW'(prod_q[PW-1:CFG_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			alpha_q      <= ALPHA_OPEN;
			time_q       <= '0;
			idle_delay_q <= RESET_IDLE_DELAY;
			lfsr_q       <= lfsr_next(RESET_SEED);
		end else begin
			if (seed_load) begin
				lfsr_q <= seed_data;
			end
			if (cmd.eval) begin
				time_q <= reach ? '0 : t_q;
				case (phase_q)
					PH_IDLE: begin
						alpha_q <= ALPHA_OPEN;
						if (reach) begin
							phase_q <= PH_CLOSING;
						end
					end
					PH_CLOSING: begin
						if (reach) begin
							alpha_q <= ALPHA_CLOSED;
							phase_q <= PH_CLOSED;
						end
					end
					PH_CLOSED: begin
						alpha_q <= ALPHA_CLOSED;
						if (reach) begin
							phase_q <= PH_OPENING;
						end
					end
					default: begin
						if (reach) begin
							alpha_q <= ALPHA_OPEN;
							phase_q <= PH_IDLE;
						end
					end
				endcase
			end
			if (cmd.write_curve) begin
				alpha_q <= (phase_q == PH_CLOSING) ? rom_val : (ALPHA_CLOSED - rom_val);
			end
			if (cmd.draw_mul) begin
				lfsr_q <= lfsr_adv;
			end
			if (cmd.draw_add) begin
				idle_delay_q <= (dsum > DSW'(TIMER_MAX)) ? TIMER_MAX : TW'(dsum);
			end
		end
	end

	// work registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_sum) begin
			t_q <= (sum > SW'(TIMER_MAX)) ? TIMER_MAX : TW'(sum);
		end
		if (cmd.eval) begin
			rem_q  <= {1'b0, dvd[DW-1:QW]};
			low_q  <= dvd[QW-1:0];
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= qbit ? (trial - {1'b0, curve_dur}) : trial;
			low_q  <= low_q << 1;
			quot_q <= QW'({quot_q, qbit});
		end
		if (cmd.draw_mul) begin
			prod_q <= PW'(cfg.delay_span_ticks) * PW'(lfsr_adv);
		end
	end

	assign cur_alpha = alpha_q;
	assign cur_phase = phase_q;

endmodule

// ===== src/eyelid_blink_alpha_sequencer.sv =====
// Eyelid blink alpha sequencer.
// Input channel (in_valid/in_ready, elapsed_ticks): one beat per animation
// update, carrying the number of 1 ms ticks since the previous update.
// Output channel (out_valid/out_ready, alpha, phase): one beat per input
// beat, the eyelid coverage (0 open, 255 closed) and the phase after it.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while no update is in flight. Writing the seed reloads the
// LFSR at once. Unknown indexes are dropped.
// An update loads the tick sum, then evaluates the phase. Inside closing or
// opening it runs 6 divider steps for the curve index plus ROM lookup; at
// the end of opening it draws the next idle delay (multiply then add).
// One update is in flight at a time; a new input beat is taken only after
// the previous result lands in the output register.
// The output register frees the controller: while the receiver stalls the
// next update is still accepted and computed, then waits to be loaded.
// Reset: idle phase, alpha 0, registers at defaults, idle delay pre-drawn.
module eyelid_blink_alpha_sequencer import ebas_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ELAPSED_W-1:0]  elapsed_ticks,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ALPHA_W-1:0]    alpha,
	output logic [PHASE_W-1:0]    phase,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	cfg_regs_t           cfg_q;
	logic                cfg_wr;
	logic                seed_load;
	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic                out_free;
	logic                out_load;
	logic [ALPHA_W-1:0]  cur_alpha;
	phase_t              cur_phase;
	logic                out_valid_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [PHASE_W-1:0]  phase_q;

	// ---------------- config registers ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// seed is not held here: it goes straight into the LFSR
	assign seed_load = cfg_wr && (cfg_index == REG_RANDOM_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.close_ticks      <= RESET_CLOSE;
			cfg_q.closed_ticks     <= RESET_CLOSED;
			cfg_q.open_ticks       <= RESET_OPEN;
			cfg_q.delay_min_ticks  <= RESET_MIN;
			cfg_q.delay_span_ticks <= RESET_SPAN;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_CLOSE_TICKS:      cfg_q.close_ticks      <= cfg_data;
				REG_CLOSED_TICKS:     cfg_q.closed_ticks     <= cfg_data;
				REG_OPEN_TICKS:       cfg_q.open_ticks       <= cfg_data;
				REG_DELAY_MIN_TICKS:  cfg_q.delay_min_ticks  <= cfg_data;
				REG_DELAY_SPAN_TICKS: cfg_q.delay_span_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- controller ----------------
	ebas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.out_load (out_load),
		.stat     (stat),
		.cmd      (cmd)
	);

	// ---------------- datapath ----------------
	ebas_dpath #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.seed_load (seed_load),
		.seed_data (cfg_data),
		.elapsed   (elapsed_ticks),
		.stat      (stat),
		.cur_alpha (cur_alpha),
		.cur_phase (cur_phase)
	);

	// ---------------- output register ----------------
	// free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			alpha_q <= cur_alpha;
			phase_q <= PHASE_W'(cur_phase);
		end
	end

	assign out_valid = out_valid_q;
	assign alpha     = alpha_q;
	assign phase     = phase_q;

`ifndef SYNTHESIS
	// one update in flight: no second input beat right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an update is in flight");

	// fully closed phase always reports full coverage
	a_closed_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase == PHASE_W'(PH_CLOSED)) |-> (alpha == ALPHA_CLOSED))
		else $error("closed phase with alpha below full");

	// idle phase always reports an open eye
	a_idle_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase == PHASE_W'(PH_IDLE)) |-> (alpha == ALPHA_OPEN))
		else $error("idle phase with nonzero alpha");
`endif

endmodule
